### design/running_median_ema_smoother_top_defines.svh
// ----------------------------------------------------------------------------
// running median smoother assertion macros
// shared helpers for the port-level checks of the smoother
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_EMA_SMOOTHER_TOP_DEFINES_SVH
`define RUNNING_MEDIAN_EMA_SMOOTHER_TOP_DEFINES_SVH

// check that holds outside reset
`define RMES_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rmes port check failed");

// check that also covers the reset cycles
`define RMES_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rmes reset check failed");

`endif

### design/rmes_pkg.sv
// ----------------------------------------------------------------------------
// rmes_pkg
// types and constants shared by the running median smoother modules
// ----------------------------------------------------------------------------
package rmes_pkg;

  localparam int SAMPLE_W = 32;
  localparam int WIN_W    = 5;
  localparam int ALPHA_W  = 16;

  localparam logic [WIN_W-1:0]   WIN_RESET   = 5'd15;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd11469;
  // one in Q1.15
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 16'h8000;

  // register indexes on the configuration port
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_ALPHA  = 1'b1;

  // per-cycle commands from the sequencer to the row of cells
  typedef struct packed {
    logic shift;     // drop the oldest sample, everything moves one cell down
    logic rot_load;  // copy held samples into the rotating ring, clear counts
    logic count;     // compare and rotate one step
  } rmes_cell_ctrl_t;

endpackage

### design/rmes_cell.sv
// ----------------------------------------------------------------------------
// rmes_cell
// one window slot: holds a sample, passes a rotating copy to its neighbour
// and counts how many window samples lie below or equal to its own
// ----------------------------------------------------------------------------
module rmes_cell #(
  parameter int CW = 5
) (
  input  logic                                  clk,
  input  rmes_pkg::rmes_cell_ctrl_t             ctrl,
  input  logic signed [rmes_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  ins,
  input  logic signed [rmes_pkg::SAMPLE_W-1:0]  sv_nb,
  input  logic signed [rmes_pkg::SAMPLE_W-1:0]  rv_nb,
  input  logic                                  rvv_nb,
  input  logic                                  own_valid,
  input  logic [CW-1:0]                         rank,
  output logic signed [rmes_pkg::SAMPLE_W-1:0]  sv,
  output logic signed [rmes_pkg::SAMPLE_W-1:0]  rv,
  output logic                                  rvv,
  output logic                                  hit
);
  import rmes_pkg::*;

  logic signed [SAMPLE_W-1:0] sv_r, sv_nxt;
  logic signed [SAMPLE_W-1:0] rv_r, rv_nxt;
  logic                       rvv_r, rvv_nxt;
  logic [CW-1:0]              below_r, below_nxt;
  logic [CW-1:0]              same_r, same_nxt;
  logic [CW:0]                upto;

  always_comb begin
    sv_nxt = sv_r;
    if (ins) begin
      sv_nxt = sample;
    end else if (ctrl.shift) begin
      sv_nxt = sv_nb;
    end
  end

  always_comb begin
    rv_nxt    = rv_r;
    rvv_nxt   = rvv_r;
    below_nxt = below_r;
    same_nxt  = same_r;
    if (ctrl.rot_load) begin
      rv_nxt    = sv_r;
      rvv_nxt   = own_valid;
      below_nxt = '0;
      same_nxt  = '0;
    end else if (ctrl.count) begin
      rv_nxt  = rv_nb;
      rvv_nxt = rvv_nb;
      if (own_valid && rvv_r) begin
        if (rv_r < sv_r) begin
          below_nxt = below_r + CW'(1);
        end else if (rv_r == sv_r) begin
          same_nxt = same_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    sv_r    <= sv_nxt;
    rv_r    <= rv_nxt;
    rvv_r   <= rvv_nxt;
    below_r <= below_nxt;
    same_r  <= same_nxt;
  end

  assign upto = {1'b0, below_r} + {1'b0, same_r};
  assign hit  = own_valid && (below_r <= rank) && ({1'b0, rank} < upto);
  assign sv   = sv_r;
  assign rv   = rv_r;
  assign rvv  = rvv_r;

endmodule

### design/rmes_ema.sv
// ----------------------------------------------------------------------------
// rmes_ema
// exponential average of the medians, one shared 17x32 multiplier
// ----------------------------------------------------------------------------
module rmes_ema (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [rmes_pkg::SAMPLE_W-1:0]  median,
  input  logic [rmes_pkg::ALPHA_W-1:0]          alpha,
  output logic signed [rmes_pkg::SAMPLE_W-1:0]  ema,
  output logic                                  done
);
  import rmes_pkg::*;

  localparam logic [2:0] E_IDLE = 3'd0;
  localparam logic [2:0] E_MA   = 3'd1;
  localparam logic [2:0] E_MB   = 3'd2;
  localparam logic [2:0] E_ADD  = 3'd3;
  localparam logic [2:0] E_DONE = 3'd4;

  localparam int PW = ALPHA_W + 1 + SAMPLE_W;

  logic [2:0]                 st_r, st_nxt;
  logic                       loaded_r, loaded_nxt;
  logic signed [SAMPLE_W-1:0] ema_r, ema_nxt;
  logic signed [PW-1:0]       acc_r, acc_nxt;
  logic signed [PW-1:0]       p2_r, p2_nxt;
  logic [ALPHA_W-1:0]         a_sat;
  logic [ALPHA_W-1:0]         op_w;
  logic signed [SAMPLE_W-1:0] op_v;
  logic signed [PW-1:0]       prod;
  logic signed [PW:0]         sum;

  assign a_sat = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
  assign op_w  = (st_r == E_MA) ? a_sat : (ALPHA_ONE - a_sat);
  assign op_v  = (st_r == E_MA) ? median : ema_r;
  assign prod  = $signed({1'b0, op_w}) * op_v;
  assign sum   = {acc_r[PW-1], acc_r} + {p2_r[PW-1], p2_r};

  always_comb begin
    st_nxt     = st_r;
    loaded_nxt = loaded_r;
    ema_nxt    = ema_r;
    acc_nxt    = acc_r;
    p2_nxt     = p2_r;
    case (st_r)
      E_IDLE: begin
        if (start) begin
          if (!loaded_r) begin
            // first median loads the average directly
            ema_nxt    = median;
            loaded_nxt = 1'b1;
            st_nxt     = E_DONE;
          end else begin
            st_nxt = E_MA;
          end
        end
      end
      E_MA: begin
        acc_nxt = prod;
        st_nxt  = E_MB;
      end
      E_MB: begin
        p2_nxt = prod;
        st_nxt = E_ADD;
      end
      E_ADD: begin
        // floor shift by 15, result always fits the sample width
        ema_nxt = sum[SAMPLE_W+14:15];
        st_nxt  = E_DONE;
      end
      E_DONE: begin
        st_nxt = E_IDLE;
      end
      default: begin
        st_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= E_IDLE;
      loaded_r <= 1'b0;
      ema_r    <= '0;
    end else begin
      st_r     <= st_nxt;
      loaded_r <= loaded_nxt;
      ema_r    <= ema_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    p2_r  <= p2_nxt;
  end

  assign ema  = ema_r;
  assign done = (st_r == E_DONE);

endmodule

### design/running_median_ema_smoother_top.sv
// ----------------------------------------------------------------------------
// running median smoother with exponential average
// from input transfer to out_valid: load, a MAX_WINDOW-step rotation of the
// cell ring that ranks the window, select, average and finish; the first
// median loads the average directly; pass-through (window 0 or 1) goes to finish
// one sample in flight: a new sample is taken only once the result is registered
// reset: window empty, average unloaded, window 15, alpha 0.35
// ----------------------------------------------------------------------------
module running_median_ema_smoother_top #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [rmes_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [rmes_pkg::SAMPLE_W-1:0]  out_smoothed,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [2:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import rmes_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int IW = $clog2(MAX_WINDOW);
  localparam int WW = (CW > WIN_W) ? CW : WIN_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_COUNT = 3'd2;
  localparam logic [2:0] ST_SEL   = 3'd3;
  localparam logic [2:0] ST_EMA   = 3'd4;
  localparam logic [2:0] ST_WAIT  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [WIN_W-1:0]   win_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic               cfg_wr;

  logic [2:0]                 st_r, st_nxt;
  logic [CW-1:0]              fc_r, fc_nxt;
  logic [IW-1:0]              cnt_r, cnt_nxt;
  logic signed [SAMPLE_W-1:0] median_r, median_nxt;
  logic signed [SAMPLE_W-1:0] res_r, res_nxt;
  logic signed [SAMPLE_W-1:0] out_smoothed_r, out_smoothed_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic          in_xfer;
  logic          pass;
  logic          take;
  logic [CW-1:0] weff;
  logic          drop;
  logic [CW-1:0] pos;
  logic [CW-1:0] rank;

  rmes_cell_ctrl_t            cell_ctrl;
  logic signed [SAMPLE_W-1:0] sv_w [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] rv_w [MAX_WINDOW];
  logic                       rvv_w [MAX_WINDOW];
  logic                       hit_w [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] med_or;

  logic                       ema_start;
  logic                       ema_done;
  logic signed [SAMPLE_W-1:0] ema_val;
  logic signed [SAMPLE_W:0]   avg_sum;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= WIN_RESET;
      alpha_r <= ALPHA_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_WINDOW: win_r <= pwdata[WIN_W-1:0];
        REG_ALPHA:  alpha_r <= pwdata[ALPHA_W-1:0];
        default: begin
          win_r <= win_r;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WINDOW: prdata = {{(32-WIN_W){1'b0}}, win_r};
      REG_ALPHA:  prdata = {{(32-ALPHA_W){1'b0}}, alpha_r};
      default:    prdata = '0;
    endcase
  end

  // window bookkeeping
  assign in_ready = (st_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign pass     = (win_r < WIN_W'(2));
  assign take     = in_xfer && !pass;
  assign weff     = (WW'(win_r) > WW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : CW'(win_r);
  assign drop     = (fc_r >= weff);
  assign pos      = drop ? (fc_r - CW'(1)) : fc_r;
  assign rank     = fc_r >> 1;

  assign cell_ctrl.shift    = take && drop;
  assign cell_ctrl.rot_load = (st_r == ST_LOAD);
  assign cell_ctrl.count    = (st_r == ST_COUNT);

  // cell k holds the k-th oldest sample, the rotating copy moves to k-1
  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    localparam int NB = (k + 1) % MAX_WINDOW;
    rmes_cell #(
      .CW (CW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .sample    (in_sample),
      .ins       (take && (pos == CW'(k))),
      .sv_nb     (sv_w[NB]),
      .rv_nb     (rv_w[NB]),
      .rvv_nb    (rvv_w[NB]),
      .own_valid (CW'(k) < fc_r),
      .rank      (rank),
      .sv        (sv_w[k]),
      .rv        (rv_w[k]),
      .rvv       (rvv_w[k]),
      .hit       (hit_w[k])
    );
  end

  // every hitting cell holds the same value, so an or picks the median
  always_comb begin
    med_or = '0;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      med_or = med_or | (hit_w[k] ? sv_w[k] : '0);
    end
  end

  assign ema_start = (st_r == ST_EMA);

  rmes_ema u_ema (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ema_start),
    .median (median_r),
    .alpha  (alpha_r),
    .ema    (ema_val),
    .done   (ema_done)
  );

  assign avg_sum = {median_r[SAMPLE_W-1], median_r} + {ema_val[SAMPLE_W-1], ema_val};

  // sequencer
  always_comb begin
    st_nxt           = st_r;
    fc_nxt           = fc_r;
    cnt_nxt          = cnt_r;
    median_nxt       = median_r;
    res_nxt          = res_r;
    out_smoothed_nxt = out_smoothed_r;
    out_valid_nxt    = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (st_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (pass) begin
            res_nxt = in_sample;
            st_nxt  = ST_FIN;
          end else begin
            fc_nxt = drop ? fc_r : (fc_r + CW'(1));
            st_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cnt_nxt = '0;
        st_nxt  = ST_COUNT;
      end
      ST_COUNT: begin
        cnt_nxt = cnt_r + IW'(1);
        if (cnt_r == IW'(MAX_WINDOW - 1)) begin
          st_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        median_nxt = med_or;
        st_nxt     = ST_EMA;
      end
      ST_EMA: begin
        st_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (ema_done) begin
          res_nxt = avg_sum[SAMPLE_W:1];
          st_nxt  = ST_FIN;
        end
      end
      ST_FIN: begin
        // output register free or being emptied in this transfer
        if (!out_valid_r || out_ready) begin
          out_smoothed_nxt = res_r;
          out_valid_nxt    = 1'b1;
          st_nxt           = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      fc_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      fc_r        <= fc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    median_r       <= median_nxt;
    res_r          <= res_nxt;
    out_smoothed_r <= out_smoothed_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_smoothed = out_smoothed_r;

endmodule

### design/rmes_checker.sv
// ----------------------------------------------------------------------------
// rmes_checker
// port-level checks on the running median smoother, bound to the top level
// ----------------------------------------------------------------------------
`include "running_median_ema_smoother_top_defines.svh"

module rmes_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [rmes_pkg::SAMPLE_W-1:0]  out_smoothed
);

  // one sample in flight: an input transfer closes the input side
  `RMES_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready)

  // a new result only appears as the block returns to idle
  `RMES_ASSERT(a_result_frees_input, $rose(out_valid) |-> $rose(in_ready))

  // a stalled result holds its value
  `RMES_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_smoothed))

  // reset empties the output and opens the input
  `RMES_ASSERT_RST(a_reset_state, !rst_n |=> !out_valid && in_ready)

endmodule

bind running_median_ema_smoother_top rmes_checker u_rmes_checker (.*);
